@@ rtl/core/lzp_pkg.sv @@
// ----------------------------------------------------------------------------
// lzp_pkg
// Shared constants, types and the context hash function of the predictor codec.
// ----------------------------------------------------------------------------
package lzp_pkg;

  // Context hash and guess table geometry
  localparam int unsigned HASH_BITS   = 21;
  localparam int unsigned HASH_SHIFT  = 5;
  localparam int unsigned TABLE_DEPTH = 1 << HASH_BITS;
  localparam int unsigned BYTE_W      = 8;

  // Output queue depth: one shown, one arriving, one in flight
  localparam int unsigned OUT_DEPTH   = 3;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef logic [HASH_BITS-1:0] hash_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  typedef enum logic {
    MODE_COMPRESS   = 1'b0,
    MODE_DECOMPRESS = 1'b1
  } codec_mode_e;

  // One result as held in the output queue
  typedef struct packed {
    logic  hit;
    byte_t data;
  } out_item_t;

  // Next context: (hash << shift) + byte, kept to HASH_BITS bits
  function automatic hash_t next_hash(hash_t h, byte_t c);
    hash_t shifted;
    shifted = h << HASH_SHIFT;
    return shifted + hash_t'(c);
  endfunction

endpackage

@@ rtl/core/lzp_ram.sv @@
// ----------------------------------------------------------------------------
// lzp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lzp_predictor_codec.sv @@
// ----------------------------------------------------------------------------
// lzp_predictor_codec
// Byte-wise predictor codec: guess table indexed by a rolling context hash.
// ----------------------------------------------------------------------------
// Takes one request per clock while no clearing pass runs and the output queue
// has room, and returns one result per request through the lookup stage and
// the output queue. The rate is set by the guess table loop: the read for a
// byte is issued in the cycle that the previous byte's read data returns, since
// the next context hash is built from that byte; a write to the address being
// read in the same cycle is forwarded. After reset the table is zeroed by a
// clearing pass, during which no request is taken; mode writes are taken
// anytime. codec_mode 0 compresses raw bytes into hit flags and literals, 1
// rebuilds bytes from hit flags and literals. Change the mode only while idle.
// ----------------------------------------------------------------------------
module lzp_predictor_codec
  import lzp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  // configuration
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  logic  codec_mode_i,
  // request channel
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t data_byte_i,
  input  logic  hit_in_i,
  // result channel
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  hit_out_o,
  output byte_t byte_out_o
);

  codec_mode_e mode_q;

  // clearing pass
  logic  clr_active_q;
  hash_t clr_addr_q;

  // context hash of the next request to enter
  hash_t hash_q, hash_d;

  // lookup stage (read data arrives here)
  logic  s1_valid_q;
  hash_t s1_addr_q;
  byte_t s1_data_q;
  logic  s1_hit_q;

  // forwarding of a write that collided with the read
  logic  fwd_q, fwd_d;
  byte_t fwd_data_q;

  // output queue
  out_item_t                oq_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     oq_wr_q, oq_rd_q;
  logic [OUT_CNT_W-1:0]     oq_cnt_q;

  logic      accept, push, pop;
  byte_t     rd_data, guess, sym, res;
  logic      hit, upd;
  hash_t     nh, rd_addr;
  logic      ram_we;
  hash_t     ram_waddr;
  byte_t     ram_wdata;
  logic [OUT_CNT_W:0] occupancy;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COMPRESS;
    end else if (cfg_valid_i) begin
      mode_q <= codec_mode_e'(codec_mode_i);
    end
  end

  // Clearing pass over the whole table after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + hash_t'(1);
      if (&clr_addr_q) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Handshakes
  assign occupancy  = {1'b0, oq_cnt_q} + (OUT_CNT_W+1)'(s1_valid_q);
  assign in_ready_o = !clr_active_q && (occupancy < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign push       = s1_valid_q;
  assign pop        = out_valid_o && out_ready_i;

  // Predict, compare and decide the table update
  always_comb begin
    guess = fwd_q ? fwd_data_q : rd_data;
    if (mode_q == MODE_COMPRESS) begin
      hit = (guess == s1_data_q);
      sym = s1_data_q;
      res = hit ? '0 : s1_data_q;
    end else begin
      hit = s1_hit_q;
      sym = s1_hit_q ? guess : s1_data_q;
      res = sym;
    end
    upd = s1_valid_q && !hit;
  end

  // Hash chain: a request in the lookup stage sets the next address
  assign nh      = next_hash(s1_addr_q, sym);
  assign hash_d  = s1_valid_q ? nh : hash_q;
  assign rd_addr = hash_d;
  assign fwd_d   = upd && (s1_addr_q == rd_addr);

  // Table port mux: clearing pass owns the write port while active
  assign ram_we    = clr_active_q || upd;
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_active_q ? '0 : s1_data_q;

  lzp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_guess_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Lookup stage and hash control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hash_q     <= '0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      hash_q     <= hash_d;
      if (accept) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= rd_addr;
      s1_data_q  <= data_byte_i;
      s1_hit_q   <= hit_in_i;
      fwd_data_q <= s1_data_q;
    end
  end

  // Output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (push) begin
        oq_wr_q <= (oq_wr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : oq_wr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        oq_rd_q <= (oq_rd_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : oq_rd_q + OUT_PTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  // Output queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[oq_wr_q] <= '{hit: hit, data: res};
    end
  end

  assign out_valid_o = (oq_cnt_q != '0);
  assign hit_out_o   = oq_q[oq_rd_q].hit;
  assign byte_out_o  = oq_q[oq_rd_q].data;

endmodule

@@ rtl/core/lzp_checker.sv @@
// ----------------------------------------------------------------------------
// lzp_checker
// Port-level checks of the predictor codec, bound to the top level.
// ----------------------------------------------------------------------------
module lzp_checker
  import lzp_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  cfg_valid_i,
  input logic  cfg_ready_o,
  input logic  codec_mode_i,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input byte_t data_byte_i,
  input logic  hit_in_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input logic  hit_out_o,
  input byte_t byte_out_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o) && $stable(hit_out_o))
    else $error("result changed while stalled");

  // Clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !in_ready_o)
    else $error("request taken before table clear");

  // A result appearing on an empty queue comes from an accepted request that passed the lookup stage
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

  // Configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind lzp_predictor_codec lzp_checker u_lzp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .codec_mode_i (codec_mode_i),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .data_byte_i  (data_byte_i),
  .hit_in_i     (hit_in_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_out_o    (hit_out_o),
  .byte_out_o   (byte_out_o)
);
